[sv/assert_macros.svh]
// Assertion macros for the checker file.
// Each macro expects clk and rst to be visible where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication in the same cycle, masked during reset.
`define AST_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Implication into the next cycle, masked during reset.
`define AST_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Implication into the next cycle, active through reset.
`define AST_NEXT_RST(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/ihp_pkg.sv]
// Shared codes and controller/datapath interface structs of the indexed max-heap.
// No dependencies.
`default_nettype none
package ihp_pkg;

  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_REMOVE = 2'd1;
  localparam logic [1:0] CMD_QUERY  = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_BAD     = 2'd2;

  localparam int IN_BITS  = 64;
  localparam int OUT_BITS = 80;

  typedef struct packed {
    logic       load;
    logic       ins_start;
    logic       rd_par;
    logic       up_move;
    logic       rd_last;
    logic       rem_take;
    logic       rd_left;
    logic       rd_right;
    logic       down_move;
    logic       place;
    logic       rd_map;
    logic       q_take;
    logic       set_stat;
    logic [1:0] stat;
    logic       finish;
  } ihp_ctl_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic       full;
    logic       pos_bad;
    logic       at_root;
    logic       up_win;
    logic       has_left;
    logic       pick_child;
    logic       is_last;
    logic       out_busy;
  } ihp_sts_t;

endpackage
`default_nettype wire

[sv/indexed_max_heap_top.sv]
// Indexed max-heap: one request at a time, one result per request.
// Full and bad requests go straight to the result, a query reads the row map, and a remove
// of the last slot needs no sift; an insert climbs level by level and other removes descend,
// then climb. The next request can be accepted while the result waits. The slowest request
// is a remove at the root of a full heap, its pace set by the single read port of the heap
// memory. Reset clears count and handshake state; memories need no clear.
`default_nettype none
module indexed_max_heap_top
  import ihp_pkg::*;
#(
  parameter int CAPACITY   = 1024,
  parameter int ROWS       = 1024,
  parameter int VALUE_BITS = 32
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 s_tvalid,
  output logic                      s_tready,
  // cmd[1:0], entry_row[11:2], entry_col[21:12], entry_value[53:22], position[63:54]
  input  wire logic [IN_BITS-1:0]   s_tdata,
  output logic                      m_tvalid,
  input  wire logic                 m_tready,
  // top_row[9:0], top_col[19:10], top_value[51:20], entry_count[62:52],
  // row_position[72:63], status[74:73], zero fill[79:75]
  output logic [OUT_BITS-1:0]       m_tdata
);

  ihp_ctl_t ctl;
  ihp_sts_t sts;

  ihp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .sts      (sts),
    .ctl      (ctl)
  );

  ihp_dpath #(
    .CAPACITY   (CAPACITY),
    .ROWS       (ROWS),
    .VALUE_BITS (VALUE_BITS)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .sts       (sts),
    .in_data   (s_tdata),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (m_tdata)
  );

endmodule
`default_nettype wire

[sv/ihp_ctrl.sv]
// Sequencer of the indexed max-heap: decodes a request and steps sift up/down.
// Depends on ihp_pkg.
`default_nettype none
module ihp_ctrl
  import ihp_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire ihp_sts_t sts,
  output ihp_ctl_t      ctl
);

  typedef enum logic [10:0] {
    S_IDLE  = 11'b00000000001,
    S_CMD   = 11'b00000000010,
    S_UP    = 11'b00000000100,
    S_UPC   = 11'b00000001000,
    S_RL    = 11'b00000010000,
    S_DOWN  = 11'b00000100000,
    S_DL    = 11'b00001000000,
    S_DC    = 11'b00010000000,
    S_PLACE = 11'b00100000000,
    S_QW    = 11'b01000000000,
    S_FIN   = 11'b10000000000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == S_IDLE);

  always_comb begin
    ctl        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          ctl.load   = 1'b1;
          state_next = S_CMD;
        end
      end
      S_CMD: begin
        case (sts.cmd)
          CMD_INSERT: begin
            if (sts.full) begin
              ctl.set_stat = 1'b1;
              ctl.stat     = ST_FULL;
              state_next   = S_FIN;
            end else begin
              ctl.ins_start = 1'b1;
              state_next    = S_UP;
            end
          end
          CMD_REMOVE: begin
            if (sts.pos_bad) begin
              ctl.set_stat = 1'b1;
              ctl.stat     = ST_BAD;
              state_next   = S_FIN;
            end else begin
              ctl.rd_last = 1'b1;
              state_next  = S_RL;
            end
          end
          CMD_QUERY: begin
            ctl.rd_map = 1'b1;
            state_next = S_QW;
          end
          default: begin
            ctl.set_stat = 1'b1;
            ctl.stat     = ST_BAD;
            state_next   = S_FIN;
          end
        endcase
      end
      S_UP: begin
        if (sts.at_root) begin
          state_next = S_PLACE;
        end else begin
          ctl.rd_par = 1'b1;
          state_next = S_UPC;
        end
      end
      S_UPC: begin
        if (sts.up_win) begin
          ctl.up_move = 1'b1;
          state_next  = S_UP;
        end else begin
          state_next = S_PLACE;
        end
      end
      S_RL: begin
        ctl.rem_take = 1'b1;
        state_next   = sts.is_last ? S_PLACE : S_DOWN;
      end
      S_DOWN: begin
        if (sts.has_left) begin
          ctl.rd_left = 1'b1;
          state_next  = S_DL;
        end else begin
          state_next = S_UP;
        end
      end
      S_DL: begin
        ctl.rd_right = 1'b1;
        state_next   = S_DC;
      end
      S_DC: begin
        if (sts.pick_child) begin
          ctl.down_move = 1'b1;
          state_next    = S_DOWN;
        end else begin
          state_next = S_UP;
        end
      end
      S_PLACE: begin
        // heap read address rests on the root, so the top is ready in S_FIN
        ctl.place  = 1'b1;
        state_next = S_FIN;
      end
      S_QW: begin
        ctl.q_take = 1'b1;
        state_next = S_FIN;
      end
      S_FIN: begin
        if (!sts.out_busy) begin
          ctl.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

[sv/ihp_dpath.sv]
// Datapath of the indexed max-heap: heap and row map memories, moving entry,
// slot and count registers, and the result register. Depends on ihp_pkg.
`default_nettype none
module ihp_dpath
  import ihp_pkg::*;
#(
  parameter int CAPACITY   = 1024,
  parameter int ROWS       = 1024,
  parameter int VALUE_BITS = 32
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire ihp_ctl_t            ctl,
  output ihp_sts_t                 sts,
  input  wire logic [IN_BITS-1:0]  in_data,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [OUT_BITS-1:0]      out_data
);

  localparam int SW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int RW = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int VB = VALUE_BITS;
  localparam int NW = 20 + VB;

  function automatic logic [RW-1:0] row_idx(input logic [9:0] row);
    logic [31:0] r;
    r = 32'(row);
    for (int k = 9; k >= 0; k--) begin
      if (r >= (32'(ROWS) << k)) r = r - (32'(ROWS) << k);
    end
    return r[RW-1:0];
  endfunction

  // latched request
  logic [1:0]  q_cmd;
  logic [9:0]  q_row, q_col, q_pos;
  logic [31:0] q_val;

  logic [NW-1:0] node, lreg;
  logic [SW-1:0] cur;
  logic [CW-1:0] cnt;
  logic [1:0]    stat;
  logic [SW-1:0] rpos;

  logic [NW-1:0] heap_mem [CAPACITY];
  logic [SW-1:0] map_mem  [ROWS];
  logic [NW-1:0] h_rd;
  logic [SW-1:0] m_rd;

  logic          h_we, m_we;
  logic [SW-1:0] h_wa, h_ra;
  logic [NW-1:0] h_wd;
  logic [RW-1:0] m_wa, m_ra;

  logic [SW:0]   lidx, ridx;
  logic [SW-1:0] parent;
  logic          r_ok, l_beat, r_beat;
  logic [VB-1:0] big_val;
  logic [63:0]   val_ext;
  logic [NW-1:0] in_node;
  logic [NW-1:0] child;

  assign lidx   = {cur, 1'b1};
  assign ridx   = lidx + 1'b1;
  assign parent = SW'((cur - 1'b1) >> 1);
  assign val_ext = 64'(signed'(q_val));
  assign in_node = {q_row, q_col, val_ext[VB-1:0]};

  assign r_ok    = 32'(ridx) < 32'(cnt);
  assign l_beat  = $signed(lreg[VB-1:0]) > $signed(node[VB-1:0]);
  assign big_val = l_beat ? lreg[VB-1:0] : node[VB-1:0];
  assign r_beat  = r_ok && ($signed(h_rd[VB-1:0]) > $signed(big_val));
  assign child   = r_beat ? h_rd : lreg;

  assign sts.cmd        = q_cmd;
  assign sts.full       = 32'(cnt) >= 32'(CAPACITY);
  assign sts.pos_bad    = 32'(q_pos) >= 32'(cnt);
  assign sts.at_root    = (cur == '0);
  assign sts.up_win     = $signed(node[VB-1:0]) > $signed(h_rd[VB-1:0]);
  assign sts.has_left   = 32'(lidx) < 32'(cnt);
  assign sts.pick_child = l_beat || r_beat;
  assign sts.is_last    = 32'(q_pos) == 32'(cnt) - 32'd1;
  assign sts.out_busy   = out_valid && !out_ready;

  // memory address and write selection
  always_comb begin
    h_ra = '0;
    if (ctl.rd_par)   h_ra = parent;
    if (ctl.rd_last)  h_ra = SW'(cnt - 1'b1);
    if (ctl.rd_left)  h_ra = lidx[SW-1:0];
    if (ctl.rd_right) h_ra = ridx[SW-1:0];
    m_ra = row_idx(q_row);
    h_we = ctl.up_move || ctl.down_move || ctl.place;
    m_we = h_we;
    h_wa = cur;
    h_wd = node;
    if (ctl.up_move)   h_wd = h_rd;
    if (ctl.down_move) h_wd = child;
    m_wa = row_idx(h_wd[NW-1:NW-10]);
  end

  always_ff @(posedge clk) begin
    if (h_we) heap_mem[h_wa] <= h_wd;
    // forward a write to the slot being read
    h_rd <= (h_we && h_wa == h_ra) ? h_wd : heap_mem[h_ra];
  end

  always_ff @(posedge clk) begin
    if (m_we) map_mem[m_wa] <= cur;
    m_rd <= map_mem[m_ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (ctl.ins_start) begin
      cnt <= cnt + 1'b1;
    end else if (ctl.rem_take) begin
      cnt <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      q_cmd <= in_data[1:0];
      q_row <= in_data[11:2];
      q_col <= in_data[21:12];
      q_val <= in_data[53:22];
      q_pos <= in_data[63:54];
      stat  <= ST_OK;
      rpos  <= '0;
    end
    if (ctl.set_stat) stat <= ctl.stat;
    if (ctl.ins_start) begin
      node <= in_node;
      cur  <= SW'(cnt);
    end
    if (ctl.rem_take) begin
      node <= h_rd;
      cur  <= SW'(q_pos);
    end
    if (ctl.up_move) cur <= parent;
    if (ctl.rd_right) lreg <= h_rd;
    if (ctl.down_move) cur <= r_beat ? ridx[SW-1:0] : lidx[SW-1:0];
    if (ctl.place && q_cmd == CMD_INSERT) rpos <= cur;
    if (ctl.q_take) rpos <= m_rd;
  end

  // result register
  logic [63:0] top_v;
  logic [31:0] cnt_w, rpos_w;
  logic        nonempty;
  assign top_v    = 64'(h_rd[VB-1:0]);
  assign cnt_w    = 32'(cnt);
  assign rpos_w   = 32'(rpos);
  assign nonempty = (cnt != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.finish) begin
      out_data[9:0]   <= nonempty ? h_rd[NW-1:NW-10] : 10'd0;
      out_data[19:10] <= nonempty ? h_rd[NW-11:NW-20] : 10'd0;
      out_data[51:20] <= nonempty ? top_v[31:0] : 32'd0;
      out_data[62:52] <= cnt_w[10:0];
      out_data[72:63] <= rpos_w[9:0];
      out_data[74:73] <= stat;
      out_data[79:75] <= '0;
    end
  end

endmodule
`default_nettype wire

[sv/ihp_check.sv]
// Port-level checker for the indexed max-heap, bound to the top level.
// Depends on ihp_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module ihp_check
  import ihp_pkg::*;
#(
  parameter int CAPACITY = 1024
) (
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                s_tvalid,
  input wire logic                s_tready,
  input wire logic [IN_BITS-1:0]  s_tdata,
  input wire logic                m_tvalid,
  input wire logic                m_tready,
  input wire logic [OUT_BITS-1:0] m_tdata
);

  logic [31:0] cnt_out;
  assign cnt_out = 32'(m_tdata[62:52]);

  `AST_NEXT_RST(a_rst_quiet, rst, !m_tvalid, "result valid right after reset")
  `AST_NEXT(a_hold, m_tvalid && !m_tready, $stable(m_tdata), "stalled result changed")
  `AST_IMPL(a_cnt_cap, m_tvalid, cnt_out <= 32'(CAPACITY), "count above capacity")
  `AST_IMPL(a_empty_top, m_tvalid && cnt_out == 32'd0, m_tdata[51:0] == 52'd0,
            "empty heap reports a top entry")
  `AST_IMPL(a_full_cnt, m_tvalid && m_tdata[74:73] == ST_FULL,
            cnt_out == 32'(CAPACITY), "full status with room left")

endmodule

bind indexed_max_heap_top ihp_check #(.CAPACITY(CAPACITY)) u_ihp_check (.*);
`default_nettype wire
